### design/dels_pkg.sv
package dels_pkg;

  // Operation codes carried by the kind field.
  typedef enum logic [2:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_REM_HEAD = 3'd2,
    KIND_REM_TAIL = 3'd3,
    KIND_RD_INDEX = 3'd4,
    KIND_RD_HEAD  = 3'd5,
    KIND_RD_TAIL  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  localparam int unsigned KindBits    = 3;
  localparam int unsigned ElemPortBits = 32;
  localparam int unsigned PosBits     = 8;
  localparam int unsigned SizePortBits = 9;

  // Per-beat result information that travels alongside the store read.
  typedef struct packed {
    status_e status;
    logic    rd;
  } res_info_t;

endpackage

### design/dels_mem.sv
module dels_mem #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic                          re_i,
  input  logic [$clog2(CAPACITY)-1:0]   addr_i,
  input  logic [ELEMENT_BITS-1:0]       wdata_i,
  output logic [ELEMENT_BITS-1:0]       rdata_o
);

  logic [ELEMENT_BITS-1:0] mem [CAPACITY];
  logic [ELEMENT_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued, so a stalled result stays put.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/dels_ctrl.sv
module dels_ctrl #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [dels_pkg::KindBits-1:0]      kind_i,
  input  logic [dels_pkg::ElemPortBits-1:0]  element_in_i,
  input  logic [dels_pkg::PosBits-1:0]       position_i,
  output logic                               mem_we_o,
  output logic                               mem_re_o,
  output logic [$clog2(CAPACITY)-1:0]        mem_addr_o,
  output logic [ELEMENT_BITS-1:0]            mem_wdata_o,
  output dels_pkg::res_info_t                info_o,
  output logic [$clog2(CAPACITY+1)-1:0]      size_o
);
  import dels_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = (CW > PosBits) ? CW : PosBits;
  localparam int unsigned EW   = (ELEMENT_BITS > ElemPortBits) ? ELEMENT_BITS : ElemPortBits;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          is_full, is_empty, in_range;
  logic [PW-1:0] pos_w, cnt_w;
  logic [CW-1:0] pos_ofs;
  logic [EW-1:0] elem_w;
  logic [AW-1:0] head_dec;
  logic          we, re;
  logic [AW-1:0] addr;
  status_e       status;

  // Store slot at a given distance from the head, wrapping at the capacity.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] ofs);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(ofs);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign pos_w    = PW'(position_i);
  assign cnt_w    = PW'(count_q);
  assign in_range = (pos_w < cnt_w);
  assign pos_ofs  = CW'(pos_w);
  assign elem_w   = EW'(element_in_i);
  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    addr    = head_q;
    status  = ST_OK;
    unique case (kind_i)
      KIND_INS_HEAD: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          head_d  = head_dec;
          count_d = count_q + CW'(1);
          we      = 1'b1;
          addr    = head_dec;
        end
      end
      KIND_INS_TAIL: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
          we      = 1'b1;
          addr    = slot_of(head_q, count_q);
        end
      end
      KIND_REM_HEAD: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          head_d  = slot_of(head_q, CW'(1));
          count_d = count_q - CW'(1);
        end
      end
      KIND_REM_TAIL: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      KIND_RD_INDEX: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          re   = 1'b1;
          addr = slot_of(head_q, pos_ofs);
        end
      end
      KIND_RD_HEAD: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          re   = 1'b1;
          addr = head_q;
        end
      end
      KIND_RD_TAIL: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          re   = 1'b1;
          addr = slot_of(head_q, count_q - CW'(1));
        end
      end
      default: begin
        // Unused code: no operation.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign mem_we_o      = accept_i & we;
  assign mem_re_o      = accept_i & re;
  assign mem_addr_o    = addr;
  assign mem_wdata_o   = elem_w[ELEMENT_BITS-1:0];
  assign info_o.status = status;
  assign info_o.rd     = re;
  assign size_o        = count_d;

endmodule

### design/double_ended_list_store_top.sv
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one item per cycle; every operation is a single access to the
// one-port element store, and the head pointer and count update in the same cycle.
// Input is stalled only while a finished result is held by a stalled output.
// Reset (asynchronous, active low) empties the list and zeroes the head pointer.
module double_ended_list_store_top #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dels_pkg::KindBits-1:0]       kind_i,
  input  logic [dels_pkg::ElemPortBits-1:0]   element_in_i,
  input  logic [dels_pkg::PosBits-1:0]        position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dels_pkg::ElemPortBits-1:0]   element_out_o,
  output logic [dels_pkg::SizePortBits-1:0]   list_size_o,
  output logic [1:0]                          status_o
);
  import dels_pkg::*;

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned SW  = (CW > SizePortBits) ? CW : SizePortBits;
  localparam int unsigned EW  = (ELEMENT_BITS > ElemPortBits) ? ELEMENT_BITS : ElemPortBits;

  logic                    accept;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_addr;
  logic [ELEMENT_BITS-1:0] mem_wdata, mem_rdata;
  res_info_t               info, info_q;
  logic [CW-1:0]           size_d, size_q;
  logic                    valid_q;
  logic [EW-1:0]           rdata_w;
  logic [SW-1:0]           size_w;

  assign in_stall_o = valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  dels_ctrl #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .element_in_i (element_in_i),
    .position_i   (position_i),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .info_o       (info),
    .size_o       (size_d)
  );

  dels_mem #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      info_q <= info;
      size_q <= size_d;
    end
  end

  // The store read register carries the element; beats without a read show zero.
  assign rdata_w       = EW'(mem_rdata);
  assign size_w        = SW'(size_q);
  assign out_valid_o   = valid_q;
  assign element_out_o = info_q.rd ? rdata_w[ElemPortBits-1:0] : '0;
  assign list_size_o   = size_w[SizePortBits-1:0];
  assign status_o      = info_q.status;

endmodule

### tb/double_ended_list_store_top_test.sv
module double_ended_list_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dels_pkg::*;

  localparam int unsigned CapacityWords = 256;
  localparam logic [2:0] KindUnused = 3'd7;
  localparam int unsigned RandomOps = 1780;
  localparam int unsigned ReportLimit = 100;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] word;
    logic [7:0]  pos;
    logic        drain;
  } list_op_t;

  typedef struct packed {
    logic [31:0] element;
    logic [8:0]  size;
    status_e     status;
  } list_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KindBits-1:0] kind_i = '0;
  logic [ElemPortBits-1:0] element_in_i = '0;
  logic [PosBits-1:0] position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ElemPortBits-1:0] element_out_o;
  logic [SizePortBits-1:0] list_size_o;
  logic [1:0] status_o;

  double_ended_list_store_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .element_in_i  (element_in_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .element_out_o (element_out_o),
    .list_size_o   (list_size_o),
    .status_o      (status_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the list. The 8-bit head pointer wraps exactly at the capacity.
  logic [31:0] shadow_words [CapacityWords];
  logic [7:0]  shadow_head = '0;
  logic [8:0]  shadow_count = '0;

  list_op_t    list_op_q [$];
  list_reply_t list_reply_q [$];
  list_op_t    next_op;
  int          total_ops = 0;
  int          ops_accepted = 0;
  int          gen_count = 0;
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_cycle = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          stall_mode = 0;

  function automatic list_reply_t apply_list_op(logic [2:0] k, logic [31:0] word,
                                                logic [7:0] pos);
    list_reply_t r;
    r.element = '0;
    r.status  = ST_OK;
    case (k)
      KIND_INS_HEAD: begin
        if (shadow_count == CapacityWords) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = shadow_head - 8'd1;
          shadow_words[shadow_head] = word;
          shadow_count = shadow_count + 9'd1;
        end
      end
      KIND_INS_TAIL: begin
        if (shadow_count == CapacityWords) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[8'(shadow_head + shadow_count[7:0])] = word;
          shadow_count = shadow_count + 9'd1;
        end
      end
      KIND_REM_HEAD: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_head = shadow_head + 8'd1;
          shadow_count = shadow_count - 9'd1;
        end
      end
      KIND_REM_TAIL: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count = shadow_count - 9'd1;
      end
      KIND_RD_INDEX: begin
        if ({1'b0, pos} >= shadow_count) r.status = ST_RANGE;
        else r.element = shadow_words[8'(shadow_head + pos)];
      end
      KIND_RD_HEAD: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.element = shadow_words[shadow_head];
      end
      KIND_RD_TAIL: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.element = shadow_words[8'(shadow_head + shadow_count[7:0] - 8'd1)];
      end
      default: begin
      end
    endcase
    r.size = shadow_count;
    return r;
  endfunction

  // Queues one operation and tracks the list size it leaves, so that the
  // random part can steer the list toward a chosen fill level.
  task automatic push_op(logic [2:0] k, logic [31:0] w, logic [7:0] p, logic drain);
    list_op_t op;
    op.kind  = k;
    op.word  = w;
    op.pos   = p;
    op.drain = drain;
    list_op_q.push_back(op);
    total_ops++;
    if ((k == KIND_INS_HEAD || k == KIND_INS_TAIL) && gen_count < CapacityWords) gen_count++;
    if ((k == KIND_REM_HEAD || k == KIND_REM_TAIL) && gen_count > 0) gen_count--;
  endtask

  function automatic void note_mismatch(string field, longint unsigned want,
                                        longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Sender: bursts of random length separated by random gaps. A beat marked
  // for draining waits until every earlier result has come back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      kind_i       <= '0;
      element_in_i <= '0;
      position_i   <= '0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        list_reply_q.push_back(apply_list_op(kind_i, element_in_i, position_i));
        ops_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (list_op_q.size() != 0 &&
                     !(list_op_q[0].drain && list_reply_q.size() != 0)) begin
          next_op = list_op_q.pop_front();
          in_valid_i   <= 1'b1;
          kind_i       <= next_op.kind;
          element_in_i <= next_op.word;
          position_i   <= next_op.pos;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and stalls in modes of random length,
  // with two long hold-offs that back the block up into its input.
  always @(posedge clk_i or negedge rst_ni) begin : reply_side
    list_reply_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (list_reply_q.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result beat, expected none, actual %0h/%0d/%0d",
                   $time, element_out_o, list_size_o, status_o);
        end else begin
          want = list_reply_q.pop_front();
          if (element_out_o !== want.element) note_mismatch("element", want.element,
                                                            element_out_o);
          if (list_size_o !== want.size) note_mismatch("size", want.size, list_size_o);
          if (status_o !== want.status) note_mismatch("status", want.status, status_o);
        end
      end
      rx_cycle++;
      if (rx_cycle == 1200 || rx_cycle == 4000) hold_left = 250;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(40, 200);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int target;
    int extra;
    int roll;
    int random_ops;
    logic [2:0] k;
    logic [7:0] p;
    logic first_of_phase;
    logic grow;
    logic reached;

    // Empty list: reads, removes and the unused kind.
    push_op(KIND_RD_HEAD, $urandom, 8'($urandom), 1'b0);
    push_op(KIND_RD_TAIL, $urandom, 8'($urandom), 1'b0);
    push_op(KIND_RD_INDEX, $urandom, 8'd0, 1'b0);
    push_op(KIND_REM_HEAD, $urandom, 8'($urandom), 1'b0);
    push_op(KIND_REM_TAIL, $urandom, 8'($urandom), 1'b0);
    push_op(KindUnused, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    // The first head insert wraps the head pointer below zero.
    push_op(KIND_INS_HEAD, 32'h0000_0000, 8'hFF, 1'b0);
    push_op(KIND_INS_TAIL, 32'hFFFF_FFFF, 8'h00, 1'b0);
    push_op(KIND_INS_HEAD, 32'hA5A5_5A5A, 8'h55, 1'b0);
    push_op(KIND_RD_INDEX, 32'h0, 8'd0, 1'b0);
    push_op(KIND_RD_INDEX, 32'h0, 8'd1, 1'b0);
    push_op(KIND_RD_INDEX, 32'h0, 8'd2, 1'b0);
    push_op(KIND_RD_INDEX, 32'h0, 8'd3, 1'b0);
    push_op(KIND_RD_INDEX, 32'hFFFF_FFFF, 8'd255, 1'b0);
    push_op(KIND_RD_HEAD, 32'h0, 8'h0, 1'b0);
    push_op(KIND_RD_TAIL, 32'h0, 8'h0, 1'b0);
    push_op(KIND_REM_TAIL, 32'h0, 8'h0, 1'b0);
    push_op(KIND_RD_TAIL, 32'h0, 8'h0, 1'b0);
    push_op(KIND_REM_HEAD, 32'h0, 8'h0, 1'b0);
    push_op(KIND_RD_HEAD, 32'h0, 8'h0, 1'b0);
    push_op(KindUnused, 32'h0, 8'h0, 1'b0);
    push_op(KIND_REM_HEAD, 32'h0, 8'h0, 1'b0);
    push_op(KIND_REM_TAIL, 32'h0, 8'h0, 1'b0);
    push_op(KIND_RD_INDEX, 32'h0, 8'd0, 1'b0);

    // Random phases, each steering the list toward a target fill level and
    // lingering there; the first one fills the list so full inserts get rejected.
    random_ops = 0;
    target = CapacityWords;
    while (random_ops < RandomOps) begin
      reached = 1'b0;
      extra = $urandom_range(5, 40);
      first_of_phase = 1'b1;
      while (extra > 0 && random_ops < RandomOps) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          k = KindUnused;
        end else if (roll < 34) begin
          k = (roll < 24) ? KIND_RD_INDEX : ((roll < 29) ? KIND_RD_HEAD : KIND_RD_TAIL);
        end else begin
          grow = (gen_count < target) || (gen_count == target && $urandom_range(0, 1) == 1);
          if ($urandom_range(0, 9) == 0) grow = !grow;
          if (grow) k = $urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL;
          else k = $urandom_range(0, 1) ? KIND_REM_HEAD : KIND_REM_TAIL;
        end
        case ($urandom_range(0, 9))
          0, 1: p = 8'($urandom);
          2: p = 8'(gen_count - 1);
          3: p = 8'(gen_count);
          default: p = (gen_count == 0) ? 8'd0 : 8'($urandom_range(0, gen_count - 1));
        endcase
        push_op(k, $urandom, p, first_of_phase);
        first_of_phase = 1'b0;
        random_ops++;
        if (gen_count == target) reached = 1'b1;
        if (reached) extra--;
      end
      case ($urandom_range(0, 3))
        0: target = CapacityWords;
        1: target = 0;
        2: target = $urandom_range(1, CapacityWords - 1);
        default: target = $urandom_range(CapacityWords - 8, CapacityWords);
      endcase
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (ops_accepted != total_ops || list_reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### double_ended_list_store_top.f
design/dels_pkg.sv
design/dels_mem.sv
design/dels_ctrl.sv
design/double_ended_list_store_top.sv
tb/double_ended_list_store_top_test.sv
